// ===== rtl/lzw_pkg.sv =====
package lzw_pkg;

	localparam int CODE_W    = 12;
	localparam int BYTE_W    = 8;
	localparam int NEXT_W    = 13;
	localparam int EPOCH_W   = 8;
	localparam int CODE_SPACE = 4096;
	localparam logic [NEXT_W-1:0] LITERALS = 13'd256;

	// epoch zero marks a slot that is empty in every string
	localparam logic [EPOCH_W-1:0] EPOCH_EMPTY = 8'd0;
	localparam logic [EPOCH_W-1:0] EPOCH_FIRST = 8'd1;
	localparam logic [EPOCH_W-1:0] EPOCH_LAST  = 8'd255;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CHECK,
		ST_EMIT_MISS,
		ST_EMIT_LAST
	} state_t;

	typedef struct packed {
		logic accept;
		logic first;
		logic start;
		logic next_probe;
		logic take_hit;
		logic insert;
		logic push_miss;
		logic push_last;
		logic clr_wr;
	} cmd_t;

	typedef struct packed {
		logic pvalid;
		logic eoi;
		logic hit;
		logic occupied;
		logic can_insert;
		logic q_full;
		logic clr_done;
		logic epoch_max;
	} status_t;

endpackage

// ===== rtl/lzw_compressor.sv =====
// lzw encoder with fixed 12-bit codes
// input channel: one byte per transaction (byte_value, end_of_input) on
// in_valid / in_stall. output channel: one code per transaction (code,
// last_code) on out_valid / out_stall, last_code set on the flushed code.
// a byte that extends a known string is handled by an accept, then one
// hash table read and compare; each extra occupied slot probed adds a
// further read and compare. a miss adds the insert and an emit, and
// end_of_input adds the flush. the next byte waits until these are done.
// codes pass through a 2-entry queue, so a stalled receiver holds results
// there while the next byte is taken; the encoder waits only when the
// queue is full.
// reset empties the queue and starts a clearing pass over the hash table
// of 2^(clog2(min(DICT_ENTRIES,4096))+1) slots, one slot a cycle, with
// in_stall high. table slots carry an 8-bit string epoch, so a string
// ending normally needs no clearing; every 255th string end repeats the
// clearing pass.
module lzw_compressor
	import lzw_pkg::*;
#(
	parameter int DICT_ENTRIES = 4096
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [BYTE_W-1:0] byte_value,
	input  logic              end_of_input,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [CODE_W-1:0] code,
	output logic              last_code
);

	cmd_t    cmd;
	status_t st;

	lzw_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.end_of_input (end_of_input),
		.st           (st),
		.cmd          (cmd),
		.in_stall     (in_stall)
	);

	lzw_dpath #(
		.DICT_ENTRIES (DICT_ENTRIES)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_value   (byte_value),
		.end_of_input (end_of_input),
		.cmd          (cmd),
		.st           (st),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.code         (code),
		.last_code    (last_code)
	);

endmodule

// ===== rtl/lzw_ctrl.sv =====
module lzw_ctrl
	import lzw_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    end_of_input,
	input  status_t st,
	output cmd_t    cmd,
	output logic    in_stall
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd = '0;
		state_d = state_q;
		in_stall = (state_q != ST_IDLE);
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (st.clr_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (!st.pvalid) begin
						cmd.first = 1'b1;
						state_d = end_of_input ? ST_EMIT_LAST : ST_IDLE;
					end else begin
						cmd.start = 1'b1;
						state_d = ST_CHECK;
					end
				end
			end
			ST_CHECK: begin
				if (st.hit) begin
					cmd.take_hit = 1'b1;
					state_d = st.eoi ? ST_EMIT_LAST : ST_IDLE;
				end else if (st.occupied) begin
					cmd.next_probe = 1'b1;
				end else begin
					cmd.insert = st.can_insert;
					state_d = ST_EMIT_MISS;
				end
			end
			ST_EMIT_MISS: begin
				if (!st.q_full) begin
					cmd.push_miss = 1'b1;
					state_d = st.eoi ? ST_EMIT_LAST : ST_IDLE;
				end
			end
			ST_EMIT_LAST: begin
				if (!st.q_full) begin
					cmd.push_last = 1'b1;
					state_d = st.epoch_max ? ST_CLEAR : ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

endmodule

// ===== rtl/lzw_dpath.sv =====
module lzw_dpath
	import lzw_pkg::*;
#(
	parameter int DICT_ENTRIES = 4096
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [BYTE_W-1:0] byte_value,
	input  logic              end_of_input,
	input  cmd_t              cmd,
	output status_t           st,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [CODE_W-1:0] code,
	output logic              last_code
);

	localparam int CODE_LIMIT = (DICT_ENTRIES < CODE_SPACE) ? DICT_ENTRIES : CODE_SPACE;
	localparam int AW = $clog2(CODE_LIMIT) + 1;
	localparam int SLOTS = 1 << AW;
	localparam int KEY_W = CODE_W + BYTE_W;
	localparam int ENT_W = EPOCH_W + KEY_W + CODE_W;
	localparam logic [NEXT_W-1:0] LIMIT_V = NEXT_W'(CODE_LIMIT);

	logic [CODE_W-1:0]  prefix_q;
	logic               pvalid_q;
	logic [NEXT_W-1:0]  next_code_q;
	logic [EPOCH_W-1:0] epoch_q;
	logic [BYTE_W-1:0]  byte_q;
	logic               eoi_q;
	logic [AW-1:0]      probe_addr_q;
	logic [AW-1:0]      clr_addr_q;
	logic [ENT_W-1:0]   mem [SLOTS];
	logic [ENT_W-1:0]   rd_data_q;

	logic [AW-1:0]      hash_in;
	logic [AW-1:0]      rd_addr;
	logic [AW-1:0]      wr_addr;
	logic [ENT_W-1:0]   wr_data;
	logic               wr_en;
	logic [KEY_W-1:0]   key_in;

	logic [EPOCH_W-1:0] rd_epoch;
	logic [CODE_W-1:0]  rd_prefix;
	logic [BYTE_W-1:0]  rd_suffix;
	logic [CODE_W-1:0]  rd_code;

	logic [CODE_W-1:0]  q_code_q [2];
	logic               q_last_q [2];
	logic               q_wr_q;
	logic               q_rd_q;
	logic [1:0]         q_cnt_q;
	logic               push;
	logic               pop;
	logic [CODE_W-1:0]  push_code;

	// fold the prefix and suffix into a table address
	assign key_in  = {byte_value, prefix_q};
	assign hash_in = key_in[AW-1:0] ^ AW'(key_in >> AW);
	assign rd_addr = cmd.start ? hash_in : probe_addr_q + AW'(1);

	assign {rd_epoch, rd_prefix, rd_suffix, rd_code} = rd_data_q;

	assign wr_en   = cmd.clr_wr || cmd.insert;
	assign wr_addr = cmd.clr_wr ? clr_addr_q : probe_addr_q;
	assign wr_data = cmd.clr_wr ? {EPOCH_EMPTY, {(KEY_W + CODE_W){1'b0}}}
	                            : {epoch_q, prefix_q, byte_q, next_code_q[CODE_W-1:0]};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			byte_q <= byte_value;
			eoi_q  <= end_of_input;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_q     <= '0;
			pvalid_q     <= 1'b0;
			next_code_q  <= LITERALS;
			epoch_q      <= EPOCH_FIRST;
			probe_addr_q <= '0;
			clr_addr_q   <= '0;
		end else begin
			if (cmd.clr_wr) begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end
			if (cmd.start) begin
				probe_addr_q <= hash_in;
			end else if (cmd.next_probe) begin
				probe_addr_q <= probe_addr_q + AW'(1);
			end
			if (cmd.insert) begin
				next_code_q <= next_code_q + NEXT_W'(1);
			end
			if (cmd.first) begin
				prefix_q <= CODE_W'(byte_value);
				pvalid_q <= 1'b1;
			end else if (cmd.take_hit) begin
				prefix_q <= rd_code;
			end else if (cmd.push_miss) begin
				prefix_q <= CODE_W'(byte_q);
			end else if (cmd.push_last) begin
				prefix_q    <= '0;
				pvalid_q    <= 1'b0;
				next_code_q <= LITERALS;
				epoch_q     <= (epoch_q == EPOCH_LAST) ? EPOCH_FIRST : epoch_q + EPOCH_W'(1);
			end
		end
	end

	// two-entry result queue
	assign push      = cmd.push_miss || cmd.push_last;
	assign push_code = prefix_q;
	assign out_valid = (q_cnt_q != 2'd0);
	assign pop       = out_valid && !out_stall;
	assign code      = q_code_q[q_rd_q];
	assign last_code = q_last_q[q_rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_code_q[q_wr_q] <= push_code;
			q_last_q[q_wr_q] <= cmd.push_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_wr_q  <= 1'b0;
			q_rd_q  <= 1'b0;
			q_cnt_q <= 2'd0;
		end else begin
			if (push) begin
				q_wr_q <= !q_wr_q;
			end
			if (pop) begin
				q_rd_q <= !q_rd_q;
			end
			q_cnt_q <= q_cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_comb begin
		st.pvalid     = pvalid_q;
		st.eoi        = eoi_q;
		st.occupied   = (rd_epoch == epoch_q);
		st.hit        = st.occupied && (rd_prefix == prefix_q) && (rd_suffix == byte_q);
		st.can_insert = (next_code_q < LIMIT_V);
		st.q_full     = (q_cnt_q == 2'd2);
		st.clr_done   = (clr_addr_q == {AW{1'b1}});
		st.epoch_max  = (epoch_q == EPOCH_LAST);
	end

endmodule

// ===== rtl/lzw_compressor_checker.sv =====
module lzw_compressor_checker
	import lzw_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              end_of_input,
	input logic              out_valid,
	input logic              out_stall,
	input logic [CODE_W-1:0] code,
	input logic              last_code
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(code) && $stable(last_code))
		else $error("stalled result changed");

	// after the last byte of a string the flush keeps the input side busy
	a_eoi_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && end_of_input |=> in_stall)
		else $error("input taken before flush");

	// coming out of reset the table is being cleared and nothing is pending
	a_reset_clear: assert property (@(posedge clk)
		$rose(arst_n) |-> in_stall && !out_valid)
		else $error("bad state after reset");

endmodule

bind lzw_compressor lzw_compressor_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.end_of_input (end_of_input),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.code         (code),
	.last_code    (last_code)
);
